// ===== rtl/ipv4_address_finder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the IPv4 address finder checker
// Shared property templates, clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_ADDRESS_FINDER_CORE_ASSERT_SVH
`define IPV4_ADDRESS_FINDER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPAF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ipaf_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 address finder package
// Character codes, byte classes and sizes shared by the finder modules.
// ----------------------------------------------------------------------------
package ipaf_pkg;

    // Characters that the scanner recognizes.
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    // Octet limits.
    localparam int unsigned OCTET_MAX   = 255;
    localparam int unsigned OCTET_CELLS = 3;
    localparam int unsigned RUN_DIGITS  = 3;

    // Widths of the run and link state.
    localparam int unsigned RUN_VALUE_BITS  = 10;
    localparam int unsigned RUN_LENGTH_BITS = 3;
    localparam int unsigned LINK_BITS       = $clog2(OCTET_CELLS + 1);

    // Widths of the result fields.
    localparam int unsigned ADDR_BITS   = 32;
    localparam int unsigned START_BITS  = 32;
    localparam int unsigned LENGTH_BITS = 4;

    // Class of one text byte.
    typedef enum logic [1:0] {
        CLS_START = 2'd0,
        CLS_DIGIT = 2'd1,
        CLS_DOT   = 2'd2,
        CLS_OTHER = 2'd3
    } byte_class_t;

    typedef logic [7:0] octet_t;

endpackage

// ===== rtl/ipaf_octet_cell.sv =====
// ----------------------------------------------------------------------------
// IPv4 address finder octet cell
// Holds one linked octet and hands it on to the next cell when a dot links
// a new octet into the candidate address.
// ----------------------------------------------------------------------------
module ipaf_octet_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            shift_en,
    input  ipaf_pkg::octet_t octet_in,
    output ipaf_pkg::octet_t octet_out
);

    ipaf_pkg::octet_t octet_reg;
    ipaf_pkg::octet_t octet_next;

    // Clear at end of text, otherwise take the neighbor's octet on a link.
    always_comb
    begin
        octet_next = octet_reg;
        if (clear)
        begin
            octet_next = '0;
        end
        else if (shift_en)
        begin
            octet_next = octet_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octet_reg <= '0;
        end
        else
        begin
            octet_reg <= octet_next;
        end
    end

    assign octet_out = octet_reg;

endmodule

// ===== rtl/ipv4_address_finder_core.sv =====
// ----------------------------------------------------------------------------
// IPv4 address finder core
// Scans a byte stream and reports dotted-quad IPv4 addresses.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready) carries one text byte per beat,
//   with end_of_text set on the final byte of each text. The output channel
//   (out_valid, out_ready) carries one beat per address found: the address,
//   the position of its first digit and the length of its text.
//   One byte is taken per cycle while in_ready is high. An address is reported
//   on the byte that ends it; the result goes to the output register, or to
//   the skid stage while the output stalls. The rate is set by the scanner
//   update of the run and link state; earlier octets move through a chain of
//   three octet cells, one cell per link, so no wide search stands in the path.
//   An output register and a one-beat skid stage follow the scanner, so a
//   new byte is taken while a result waits; in_ready drops only when both
//   hold results that the receiver has not taken.
//   Reset clears the position counter, the candidate and both output
//   stages. After a byte with end_of_text the scanner state returns to its
//   reset value and the next byte is at position zero.
// ----------------------------------------------------------------------------
module ipv4_address_finder_core #(
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] address_value,
    output logic [31:0] start_position,
    output logic [3:0]  match_length
);

    localparam int unsigned CELLS = ipaf_pkg::OCTET_CELLS;
    localparam int unsigned RVB   = ipaf_pkg::RUN_VALUE_BITS;
    localparam int unsigned RLB   = ipaf_pkg::RUN_LENGTH_BITS;
    localparam int unsigned LB    = ipaf_pkg::LINK_BITS;
    localparam int unsigned AB    = ipaf_pkg::ADDR_BITS;
    localparam int unsigned SB    = ipaf_pkg::START_BITS;
    localparam int unsigned LENB  = ipaf_pkg::LENGTH_BITS;

    // Result beat as held in the output stages.
    typedef struct packed {
        logic [AB-1:0]   addr;
        logic [SB-1:0]   start;
        logic [LENB-1:0] length;
    } result_t;

    // Scanner state.
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [RVB-1:0]           run_value_reg, run_value_next;
    logic [RLB-1:0]           run_length_reg, run_length_next;
    logic                     run_lz_reg, run_lz_next;
    logic [LB-1:0]            linked_reg, linked_next;
    logic [POSITION_BITS-1:0] cand_reg, cand_next;
    ipaf_pkg::byte_class_t    prev_cls_reg, prev_cls_next;

    // Output stages.
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    // Octet cell chain.
    ipaf_pkg::octet_t cell_in  [CELLS];
    ipaf_pkg::octet_t cell_out [CELLS];
    logic             link_shift;

    logic                  accept;
    ipaf_pkg::byte_class_t cls;
    logic [3:0]            digit;
    logic                  emit;
    logic [3:0]            end_low;
    logic [RVB-1:0]        run_value_x10;
    result_t               new_result;

    // A run is a valid octet when it has one to three digits, stays within
    // range and has no leading zero on more than one digit.
    function automatic logic octet_ok(
        input logic [RVB-1:0] value,
        input logic [RLB-1:0] length,
        input logic           lz
    );
        logic ok;
        ok = (length >= RLB'(1)) && (length <= RLB'(ipaf_pkg::RUN_DIGITS));
        if (value > RVB'(ipaf_pkg::OCTET_MAX))
        begin
            ok = 1'b0;
        end
        if (lz && (length > RLB'(1)))
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    // Byte classification.
    always_comb
    begin
        if ((text_byte >= ipaf_pkg::CHAR_ZERO) && (text_byte <= ipaf_pkg::CHAR_NINE))
        begin
            cls = ipaf_pkg::CLS_DIGIT;
        end
        else if (text_byte == ipaf_pkg::CHAR_DOT)
        begin
            cls = ipaf_pkg::CLS_DOT;
        end
        else
        begin
            cls = ipaf_pkg::CLS_OTHER;
        end
    end

    assign digit         = 4'(text_byte - ipaf_pkg::CHAR_ZERO);
    assign run_value_x10 = (run_value_reg << 3) + (run_value_reg << 1) + RVB'(digit);

    // Scanner next-state logic for one accepted byte.
    always_comb
    begin
        run_value_next  = run_value_reg;
        run_length_next = run_length_reg;
        run_lz_next     = run_lz_reg;
        linked_next     = linked_reg;
        cand_next       = cand_reg;
        link_shift      = 1'b0;
        emit            = 1'b0;
        end_low         = pos_reg[3:0];

        if (cls == ipaf_pkg::CLS_DIGIT)
        begin
            if (prev_cls_reg != ipaf_pkg::CLS_DIGIT)
            begin
                if (prev_cls_reg != ipaf_pkg::CLS_DOT)
                begin
                    linked_next = '0;
                end
                if (linked_next == '0)
                begin
                    cand_next = pos_reg;
                end
                run_value_next  = RVB'(digit);
                run_length_next = RLB'(1);
                run_lz_next     = (digit == 4'd0);
            end
            else if (run_length_reg < RLB'(ipaf_pkg::RUN_DIGITS + 1))
            begin
                run_length_next = run_length_reg + RLB'(1);
                if (run_length_reg < RLB'(ipaf_pkg::RUN_DIGITS))
                begin
                    run_value_next = run_value_x10;
                end
            end
            // The final byte of the text may itself end an address.
            end_low = pos_reg[3:0] + 4'd1;
            if (end_of_text && (linked_next == LB'(CELLS)) &&
                octet_ok(run_value_next, run_length_next, run_lz_next))
            begin
                emit        = 1'b1;
                linked_next = '0;
            end
        end
        else
        begin
            if (prev_cls_reg == ipaf_pkg::CLS_DIGIT)
            begin
                if ((linked_reg == LB'(CELLS)) &&
                    octet_ok(run_value_reg, run_length_reg, run_lz_reg))
                begin
                    emit        = 1'b1;
                    linked_next = '0;
                end
                else if ((cls == ipaf_pkg::CLS_DOT) &&
                         octet_ok(run_value_reg, run_length_reg, run_lz_reg) &&
                         (linked_reg < LB'(CELLS)))
                begin
                    link_shift  = 1'b1;
                    linked_next = linked_reg + LB'(1);
                end
                else
                begin
                    linked_next = '0;
                end
            end
            else
            begin
                linked_next = '0;
            end
        end
    end

    assign prev_cls_next = cls;
    assign pos_next      = pos_reg + POSITION_BITS'(1);

    // Scanner registers; end of text returns them to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            run_value_reg  <= '0;
            run_length_reg <= '0;
            run_lz_reg     <= 1'b0;
            linked_reg     <= '0;
            cand_reg       <= '0;
            prev_cls_reg   <= ipaf_pkg::CLS_START;
        end
        else if (accept)
        begin
            if (end_of_text)
            begin
                pos_reg        <= '0;
                run_value_reg  <= '0;
                run_length_reg <= '0;
                run_lz_reg     <= 1'b0;
                linked_reg     <= '0;
                cand_reg       <= '0;
                prev_cls_reg   <= ipaf_pkg::CLS_START;
            end
            else
            begin
                pos_reg        <= pos_next;
                run_value_reg  <= run_value_next;
                run_length_reg <= run_length_next;
                run_lz_reg     <= run_lz_next;
                linked_reg     <= linked_next;
                cand_reg       <= cand_next;
                prev_cls_reg   <= prev_cls_next;
            end
        end
    end

    // Chain of octet cells: the newest octet enters cell 0, the oldest
    // octet sits in the last cell.
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_in[i] = run_value_reg[7:0];
        end
        else
        begin : g_link
            assign cell_in[i] = cell_out[i-1];
        end

        ipaf_octet_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (accept && end_of_text),
            .shift_en  (accept && link_shift),
            .octet_in  (cell_in[i]),
            .octet_out (cell_out[i])
        );
    end

    // Assemble the result: oldest octet in the top byte.
    always_comb
    begin
        new_result.addr = AB'(run_value_next[7:0]);
        for (int i = 0; i < CELLS; i++)
        begin
            new_result.addr[8*(i+1) +: 8] = cell_out[i];
        end
        new_result.start  = SB'(cand_next);
        new_result.length = end_low - cand_next[3:0];
    end

    // Output register with a one-beat skid stage behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept && emit;
                out_data_next  = new_result;
            end
        end
        else if (accept && emit)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = new_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign address_value  = out_data_reg.addr;
    assign start_position = out_data_reg.start;
    assign match_length   = out_data_reg.length;

endmodule

// ===== rtl/ipaf_checker.sv =====
// ----------------------------------------------------------------------------
// IPv4 address finder checker
// Port-level assertions on the finder core, attached to it by a bind.
// ----------------------------------------------------------------------------
`include "ipv4_address_finder_core_assert.svh"

module ipaf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] address_value,
    input logic [31:0] start_position,
    input logic [3:0]  match_length
);

    // A reported address spans seven to fifteen characters.
    `IPAF_ASSERT_SAME(a_length_range, clk, rst_n, out_valid, (match_length >= 4'd7) && (match_length <= 4'd15), "match length out of range")

    // Input stalls only when a result is waiting at the output.
    `IPAF_ASSERT_SAME(a_stall_needs_result, clk, rst_n, !in_ready, out_valid, "input stalled with no pending result")

    // A stalled result stays valid.
    `IPAF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `IPAF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(address_value) && $stable(start_position) && $stable(match_length), "result changed while stalled")

endmodule

bind ipv4_address_finder_core ipaf_checker u_ipaf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .address_value  (address_value),
    .start_position (start_position),
    .match_length   (match_length)
);
